/* rtl/ptc_pkg.sv */
`default_nettype none

package ptc_pkg;

  // Default formula capacity in symbols
  localparam int MAX_LEN_DEFAULT = 128;

  typedef logic [7:0] sym_t;
  typedef logic [31:0] tt_t;
  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_TAUT      = 2'd0;
  localparam verdict_t VERDICT_NOT       = 2'd1;
  localparam verdict_t VERDICT_MALFORMED = 2'd2;
  localparam verdict_t VERDICT_TOO_LONG  = 2'd3;

  localparam sym_t CH_K = 8'h4B;
  localparam sym_t CH_A = 8'h41;
  localparam sym_t CH_N = 8'h4E;
  localparam sym_t CH_C = 8'h43;
  localparam sym_t CH_E = 8'h45;
  localparam sym_t CH_P = 8'h70;
  localparam sym_t CH_Q = 8'h71;
  localparam sym_t CH_R = 8'h72;
  localparam sym_t CH_S = 8'h73;
  localparam sym_t CH_T = 8'h74;

  localparam tt_t TT_ALL_ONES = 32'hFFFF_FFFF;

  function automatic logic is_var(input sym_t c);
    return (c == CH_P) || (c == CH_Q) || (c == CH_R) || (c == CH_S) || (c == CH_T);
  endfunction

  function automatic logic is_binary(input sym_t c);
    return (c == CH_K) || (c == CH_A) || (c == CH_C) || (c == CH_E);
  endfunction

  function automatic logic is_symbol(input sym_t c);
    return is_var(c) || is_binary(c) || (c == CH_N);
  endfunction

  // Truth table of a variable over the 32 assignments (p is the high index bit)
  function automatic tt_t var_table(input sym_t c);
    tt_t t;
    unique case (c)
      CH_P:    t = 32'hFFFF_0000;
      CH_Q:    t = 32'hFF00_FF00;
      CH_R:    t = 32'hF0F0_F0F0;
      CH_S:    t = 32'hCCCC_CCCC;
      CH_T:    t = 32'hAAAA_AAAA;
      default: t = '0;
    endcase
    return t;
  endfunction

  // x is the top of stack, y the entry below it
  function automatic tt_t apply_binary(input sym_t op, input tt_t x, input tt_t y);
    tt_t r;
    case (op)
      CH_K:    r = x & y;
      CH_A:    r = x | y;
      CH_C:    r = ~x | y;
      default: r = ~(x ^ y);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ptc_ram.sv */
`default_nettype none

module ptc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/prefix_logic_tautology_checker_unit.sv */
`default_nettype none

// Channel   Handshake              Payload                          Direction
// -------   --------------------   ------------------------------   ------------
// symbol    sym_valid / sym_stall  symbol[7:0], last                into block
// result    res_valid / res_stall  verdict[1:0], truth_table[31:0]  out of block
//
// Load: each accepted request with a recognized symbol writes it to the symbol RAM while it is not full.
// Scan after the request with last: a fetch state, then S_EVAL for each variable or N;
// a binary operator adds S_COMBINE (second operand from the stack RAM); S_FINAL settles the
// verdict and S_DONE loads the result; underflow, overlong and empty skip straight to S_DONE.
// sym_stall is high from the last request until the result is loaded; a stalled
// result register holds S_DONE. Synchronous reset clears count, level, too_long, res_valid and state.

module prefix_logic_tautology_checker_unit #(
  parameter int MAX_LEN = ptc_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sym_valid,
  output logic             sym_stall,
  input  wire logic [7:0]  symbol,
  input  wire logic        last,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       verdict,
  output logic [31:0]      truth_table
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_EVAL,
    S_COMBINE,
    S_FINAL,
    S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] count;       // stored symbols
  logic          too_long;
  logic [CW-1:0] idx;         // symbols still to scan
  logic [CW-1:0] level;       // stack depth, top held in tos
  ptc_pkg::tt_t  tos;
  ptc_pkg::sym_t op_sym;
  ptc_pkg::verdict_t fin_verdict;
  ptc_pkg::tt_t      fin_table;

  logic          accept;
  logic          is_sym;
  logic          count_full;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] lvl_m1;
  logic [CW-1:0] lvl_m2;
  logic          more;
  logic          unary_ok;

  ptc_pkg::sym_t sym_q;
  ptc_pkg::tt_t  stk_q;
  logic          sym_rd_en;
  logic          stk_wr_en;
  logic          stk_rd_en;

  assign sym_stall  = (state != S_LOAD);
  assign accept     = sym_valid && !sym_stall;
  assign is_sym     = ptc_pkg::is_symbol(symbol);
  assign count_full = (count == CW'(MAX_LEN));
  assign count_next = (is_sym && !count_full) ? count + 1'b1 : count;
  assign idx_m1     = idx - 1'b1;
  assign lvl_m1     = level - 1'b1;
  assign lvl_m2     = level - 2'd2;
  assign more       = (idx != '0);

  // Variables push; N needs one operand already on the stack
  assign unary_ok = ptc_pkg::is_var(sym_q) || ((sym_q == ptc_pkg::CH_N) && (level != '0));

  // Prefetch the next symbol whenever the current step finishes this cycle
  assign sym_rd_en = (state == S_FETCH) ||
                     ((state == S_EVAL) && unary_ok && more) ||
                     ((state == S_COMBINE) && more);

  // Spill the old top on a push; fetch the second operand for a binary op
  assign stk_wr_en = (state == S_EVAL) && ptc_pkg::is_var(sym_q) && (level != '0);
  assign stk_rd_en = (state == S_EVAL) && ptc_pkg::is_binary(sym_q) && (level >= CW'(2));

  ptc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_sym_ram (
    .clk     (clk),
    .wr_en   (accept && is_sym && !count_full),
    .wr_addr (count[AW-1:0]),
    .wr_data (symbol),
    .rd_en   (sym_rd_en),
    .rd_addr (idx_m1[AW-1:0]),
    .rd_data (sym_q)
  );

  ptc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_LEN)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (lvl_m1[AW-1:0]),
    .wr_data (tos),
    .rd_en   (stk_rd_en),
    .rd_addr (lvl_m2[AW-1:0]),
    .rd_data (stk_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      too_long  <= 1'b0;
      level     <= '0;
      res_valid <= 1'b0;
    end else begin
      // Drop the result once it is taken; S_DONE reloads it on its own
      if (res_valid && !res_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (last) begin
              count    <= '0;
              too_long <= 1'b0;
              level    <= '0;
              if (too_long || (is_sym && count_full)) begin
                fin_verdict <= ptc_pkg::VERDICT_TOO_LONG;
                fin_table   <= '0;
                state       <= S_DONE;
              end else if (count_next == '0) begin
                // Empty formula
                fin_verdict <= ptc_pkg::VERDICT_MALFORMED;
                fin_table   <= '0;
                state       <= S_DONE;
              end else begin
                idx   <= count_next;
                state <= S_FETCH;
              end
            end else if (is_sym) begin
              if (count_full) begin
                too_long <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
            end
          end
        end

        S_FETCH: begin
          idx   <= idx_m1;
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (unary_ok) begin
            if (ptc_pkg::is_var(sym_q)) begin
              tos   <= ptc_pkg::var_table(sym_q);
              level <= level + 1'b1;
            end else begin
              tos <= ~tos;
            end
            if (more) begin
              idx <= idx_m1;
            end else begin
              state <= S_FINAL;
            end
          end else if (ptc_pkg::is_binary(sym_q) && (level >= CW'(2))) begin
            op_sym <= sym_q;
            state  <= S_COMBINE;
          end else begin
            // Stack underflow
            fin_verdict <= ptc_pkg::VERDICT_MALFORMED;
            fin_table   <= '0;
            state       <= S_DONE;
          end
        end

        S_COMBINE: begin
          tos   <= ptc_pkg::apply_binary(op_sym, tos, stk_q);
          level <= lvl_m1;
          if (more) begin
            idx   <= idx_m1;
            state <= S_EVAL;
          end else begin
            state <= S_FINAL;
          end
        end

        S_FINAL: begin
          if (level == CW'(1)) begin
            fin_verdict <= (tos == ptc_pkg::TT_ALL_ONES) ? ptc_pkg::VERDICT_TAUT
                                                         : ptc_pkg::VERDICT_NOT;
            fin_table   <= tos;
          end else begin
            // Leftover operands
            fin_verdict <= ptc_pkg::VERDICT_MALFORMED;
            fin_table   <= '0;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // Hold until the result register is free
          if (!res_valid || !res_stall) begin
            res_valid   <= 1'b1;
            verdict     <= fin_verdict;
            truth_table <= fin_table;
            state       <= S_LOAD;
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ptc_pkg::*;

  localparam int FORMULA_CAP  = MAX_LEN_DEFAULT;
  localparam int REQUEST_GOAL = 800;
  localparam int CYCLE_LIMIT  = 1000000;
  // Allow time for a full-length scan again after the end.
  localparam int DRAIN_CYCLES = 2 * FORMULA_CAP + 40;
  localparam int HOLD_CYCLES  = 400;

  localparam sym_t VAR_SYMS[5] = '{CH_P, CH_Q, CH_R, CH_S, CH_T};
  localparam sym_t BIN_SYMS[4] = '{CH_K, CH_A, CH_C, CH_E};

  typedef struct {
    verdict_t verdict;
    tt_t      truth;
  } outcome_t;

  typedef enum int {
    SHAPE_PLAIN,
    SHAPE_TAUT,
    SHAPE_BROKEN,
    SHAPE_NOISE,
    SHAPE_FULL,
    SHAPE_OVERLONG
  } shape_t;

  // Scoreboard: keep a private copy of the formula being loaded, score it when
  // the request with last arrives, and queue the verdict for the result side.
  class tautology_scoreboard;
    sym_t     formula[$];
    bit       overflow = 1'b0;
    outcome_t awaited[$];
    int       errors = 0;

    static function bit is_formula_char(sym_t c);
      case (c)
        CH_P, CH_Q, CH_R, CH_S, CH_T, CH_K, CH_A, CH_C, CH_E, CH_N: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Walk the stored symbols right to left over a stack of 32-bit truth tables.
    function outcome_t judge_formula();
      outcome_t o;
      tt_t      stk[$];
      tt_t      x;
      sym_t     c;
      o.verdict = VERDICT_MALFORMED;
      o.truth   = '0;
      for (int i = formula.size() - 1; i >= 0; i--) begin
        c = formula[i];
        case (c)
          CH_P: stk.push_back(32'hFFFF_0000);
          CH_Q: stk.push_back(32'hFF00_FF00);
          CH_R: stk.push_back(32'hF0F0_F0F0);
          CH_S: stk.push_back(32'hCCCC_CCCC);
          CH_T: stk.push_back(32'hAAAA_AAAA);
          CH_N: begin
            if (stk.size() < 1) return o;
            stk[$] = ~stk[$];
          end
          default: begin
            if (stk.size() < 2) return o;
            x = stk.pop_back();
            case (c)
              CH_K:    stk[$] = x & stk[$];
              CH_A:    stk[$] = x | stk[$];
              CH_C:    stk[$] = ~x | stk[$];
              default: stk[$] = ~(x ^ stk[$]);
            endcase
          end
        endcase
      end
      if (stk.size() != 1) return o;
      o.truth   = stk[0];
      o.verdict = (stk[0] == TT_ALL_ONES) ? VERDICT_TAUT : VERDICT_NOT;
      return o;
    endfunction

    function void note_request(sym_t c, bit fin);
      outcome_t o;
      if (is_formula_char(c)) begin
        if (formula.size() < FORMULA_CAP) formula.push_back(c);
        else overflow = 1'b1;
      end
      if (fin) begin
        if (overflow) begin
          o.verdict = VERDICT_TOO_LONG;
          o.truth   = '0;
        end else begin
          o = judge_formula();
        end
        awaited.push_back(o);
        formula.delete();
        overflow = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(verdict_t v, tt_t t);
      outcome_t o;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result verdict=%0d table=%h", v, t));
        return;
      end
      o = awaited.pop_front();
      if (v !== o.verdict)
        report_mismatch($sformatf("verdict %0d, expected %0d", v, o.verdict));
      if (t !== o.truth)
        report_mismatch($sformatf("truth_table %h, expected %h", t, o.truth));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        sym_valid;
  logic        sym_stall;
  logic [7:0]  symbol;
  logic        last;
  logic        res_valid;
  logic        res_stall;
  logic [1:0]  verdict;
  logic [31:0] truth_table;

  tautology_scoreboard sb;
  int requests_sent = 0;
  int cycle_count   = 0;
  bit hold_request  = 1'b0;

  always #4 clk = ~clk;

  prefix_logic_tautology_checker_unit uut (
    .clk         (clk),
    .rst         (rst),
    .sym_valid   (sym_valid),
    .sym_stall   (sym_stall),
    .symbol      (symbol),
    .last        (last),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .verdict     (verdict),
    .truth_table (truth_table)
  );

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte the block skips; a byte that happens to be a symbol becomes a blank.
  function automatic sym_t noise_byte();
    sym_t c;
    c = sym_t'($urandom_range(0, 255));
    if (tautology_scoreboard::is_formula_char(c)) c = 8'h20;
    return c;
  endfunction

  // Append a well-formed prefix formula of about target symbols. Open counts
  // the operand slots still unfilled; once the length would reach the target,
  // close every slot with a variable.
  function automatic void grow_formula(int target, ref sym_t f[$]);
    int open;
    int r;
    open = 1;
    while (open > 0) begin
      r = $urandom_range(0, 9);
      if (f.size() + open >= target || r < 3) begin
        f.push_back(VAR_SYMS[$urandom_range(0, 4)]);
        open--;
      end else if (r < 5) begin
        f.push_back(CH_N);
      end else begin
        f.push_back(BIN_SYMS[$urandom_range(0, 3)]);
        open++;
      end
    end
  endfunction

  // Offer one request at the falling edge and hold it until accepted.
  task automatic send_request(sym_t c, bit fin, bit fast);
    int gap;
    @(negedge clk);
    sym_valid <= 1'b1;
    symbol    <= c;
    last      <= fin;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
    sb.note_request(c, fin);
    requests_sent++;
    gap = fast ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      sym_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_request(sym_t'(s[i]), i == s.len() - 1, 1'b0);
  endtask

  // Sprinkle skipped bytes through the formula; sometimes let a trailing
  // skipped byte carry last instead of the final symbol.
  task automatic send_formula(ref sym_t body[$], input bit fast);
    bit tail;
    tail = (body.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (body[i]) begin
      if ($urandom_range(0, 9) == 0) send_request(noise_byte(), 1'b0, fast);
      send_request(body[i], !tail && (i == body.size() - 1), fast);
    end
    if (tail) send_request(noise_byte(), 1'b1, fast);
  endtask

  // Drop valid and hold the sender until every verdict has come back.
  task automatic wait_drained();
    @(negedge clk);
    sym_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sym_t   body[$];
    sym_t   x[$];
    shape_t shape;
    bit     fast;
    int     r;
    int     formula_idx;
    rst       = 1'b1;
    sym_valid = 1'b0;
    symbol    = '0;
    last      = 1'b0;
    sb = new;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: each variable, each operator, a tautology, underflow,
    // leftovers, a skipped byte carrying last, and empty formulas.
    send_text("p");
    send_text("Np");
    send_text("Kpq");
    send_text("Arq");
    send_text("Cst");
    send_text("Eqt ");
    send_text("ApNp");
    send_text("Kp");
    send_text("pq");
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    wait_drained();

    formula_idx = 0;
    while (requests_sent < REQUEST_GOAL) begin
      body.delete();
      x.delete();
      fast = ($urandom_range(0, 3) == 0);
      // Cover the capacity boundary first: exactly full, then one past.
      if (formula_idx == 0) shape = SHAPE_FULL;
      else if (formula_idx == 1) shape = SHAPE_OVERLONG;
      else begin
        r = $urandom_range(0, 99);
        if (r < 58) shape = SHAPE_PLAIN;
        else if (r < 72) shape = SHAPE_TAUT;
        else if (r < 86) shape = SHAPE_BROKEN;
        else if (r < 96) shape = SHAPE_NOISE;
        else if (r < 98) shape = SHAPE_FULL;
        else shape = SHAPE_OVERLONG;
      end

      case (shape)
        SHAPE_PLAIN: begin
          r = $urandom_range(0, 99);
          if (r < 70) grow_formula($urandom_range(1, 12), body);
          else if (r < 95) grow_formula($urandom_range(13, 40), body);
          else grow_formula($urandom_range(41, 126), body);
        end
        SHAPE_TAUT: begin
          // X or not X, X implies X, X equals X: all true everywhere.
          grow_formula($urandom_range(1, 8), x);
          case ($urandom_range(0, 2))
            0: body = {CH_A, x, CH_N, x};
            1: body = {CH_C, x, x};
            default: body = {CH_E, x, x};
          endcase
        end
        SHAPE_BROKEN: begin
          grow_formula($urandom_range(1, 12), body);
          case ($urandom_range(0, 2))
            0: body.delete($urandom_range(0, body.size() - 1));
            1: body.push_back(VAR_SYMS[$urandom_range(0, 4)]);
            default: body.push_front(BIN_SYMS[$urandom_range(0, 3)]);
          endcase
        end
        SHAPE_NOISE: begin
          repeat ($urandom_range(0, 6)) body.push_back(sym_t'($urandom_range(0, 255)));
        end
        SHAPE_FULL: begin
          grow_formula(FORMULA_CAP - 1, body);
          if (body.size() < FORMULA_CAP) body.push_front(CH_N);
        end
        default: grow_formula(FORMULA_CAP + 1 + $urandom_range(0, 10), body);
      endcase

      // Park the result side for a long stretch while requests keep coming.
      if (formula_idx == 6) hold_request = 1'b1;
      if (formula_idx == 20) wait_drained();
      send_formula(body, fast);
      formula_idx++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Result-side stall: runs of free cycles, short stalls, rare long stalls,
  // and one long hold-off on request from the stimulus.
  initial begin
    int  r;
    int  run;
    bit  stall_val;
    res_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_val    = 1'b1;
        run          = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_val = 1'b0;
          run       = $urandom_range(1, 20);
        end else if (r < 90) begin
          stall_val = 1'b1;
          run       = $urandom_range(1, 3);
        end else begin
          stall_val = 1'b1;
          run       = $urandom_range(10, 50);
        end
      end
      res_stall <= stall_val;
      repeat (run) @(negedge clk);
    end
  end

  // Check every accepted result against the oldest queued verdict.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(verdict, truth_table);
  end

  // Watchdog: abort if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
